/* rtl/krt_pkg.sv */
// krt_pkg: shared constants, command and status codes, word types
// for the keyed record table; no dependencies
package krt_pkg;

  localparam int KRT_ENTRIES = 64;
  localparam int KRT_DATA_W  = 32;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_LIST   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [KRT_DATA_W-1:0] part_key;
    logic signed [KRT_DATA_W-1:0] amount;
  } krt_req_t;

  typedef struct packed {
    logic [2:0]                   status;
    logic signed [KRT_DATA_W-1:0] out_key;
    logic signed [KRT_DATA_W-1:0] out_quantity;
    logic                         last;
  } krt_rsp_t;

endpackage

/* rtl/krt_chan_if.sv */
// krt_chan_if: valid/ready channel carrying one word of type T
// no dependencies; instantiated with the word types of krt_pkg
interface krt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/krt_ram.sv */
// krt_ram: generic single-write, single-read ram with registered read
// depends on krt_pkg for default sizes
module krt_ram import krt_pkg::*; #(
  parameter int WIDTH = KRT_DATA_W,
  parameter int DEPTH = KRT_ENTRIES
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/keyed_record_table.sv */
// keyed_record_table: associative table of keyed signed quantities with
// insert, search, saturating update and sorted listing
// depends on krt_pkg, krt_chan_if and krt_ram
//
//   channel  dir  word       contents
//   req_i    in   krt_req_t  command, part_key, amount
//   rsp_o    out  krt_rsp_t  status, out_key, out_quantity, last
//
// one scan loop reads the key and quantity rams one entry per cycle, with
// registered reads; insert, search and update give their word when a match
// is found or the scan ends, a full insert or empty list without any scan;
// a list runs one full scan per word
// reset clears the count, state and valid flags; ram contents need no clearing
// req_i is ready only between items; a stalled rsp_o holds the sequencer
// in its emit step while the output register is occupied
module keyed_record_table import krt_pkg::*; #(
  parameter int ENTRIES = KRT_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  krt_chan_if.sink    req_i,
  krt_chan_if.source  rsp_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;

  // latched request
  logic [1:0]        cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] amt_q, amt_d;

  // scan pointer: idx is the next address, cidx the entry now on rdata
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             cv_q, cv_d;
  logic [IDX_W-1:0] cidx_q, cidx_d;

  // listing: best candidate of this pass, and the key last emitted
  logic               have_best_q, have_best_d;
  logic signed [31:0] best_key_q, best_key_d;
  logic signed [31:0] best_qty_q, best_qty_d;
  logic               have_prev_q, have_prev_d;
  logic signed [31:0] prev_key_q, prev_key_d;
  logic [CNT_W-1:0]   rank_q, rank_d;

  // pending result word
  logic [2:0]         res_status_q, res_status_d;
  logic signed [31:0] res_key_q, res_key_d;
  logic signed [31:0] res_qty_q, res_qty_d;
  logic               res_last_q, res_last_d;

  // output register
  logic     out_valid_q, out_valid_d;
  krt_rsp_t out_q;
  logic     out_load;
  logic     out_free;

  // ram ports
  logic               key_we, qty_we;
  logic [IDX_W-1:0]   waddr;
  logic signed [31:0] qty_wdata;
  logic signed [31:0] key_rd, qty_rd;

  // update arithmetic
  logic signed [32:0] sum;
  logic signed [31:0] sat_qty;

  krt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (key_rd)
  );

  krt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_qty_ram (
    .clk_i   (clk_i),
    .we_i    (qty_we),
    .waddr_i (waddr),
    .wdata_i (qty_wdata),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (qty_rd)
  );

  // saturating add for update
  assign sum = {qty_rd[31], qty_rd} + {amt_q[31], amt_q};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat_qty = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_qty = sum[31:0];
    end
  end

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    amt_d        = amt_q;
    idx_d        = idx_q;
    cv_d         = cv_q;
    cidx_d       = cidx_q;
    have_best_d  = have_best_q;
    best_key_d   = best_key_q;
    best_qty_d   = best_qty_q;
    have_prev_d  = have_prev_q;
    prev_key_d   = prev_key_q;
    rank_d       = rank_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_qty_d    = res_qty_q;
    res_last_d   = res_last_q;
    key_we       = 1'b0;
    qty_we       = 1'b0;
    waddr        = count_q[IDX_W-1:0];
    qty_wdata    = amt_q;
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          cmd_d        = req_i.data.command;
          key_d        = req_i.data.part_key;
          amt_d        = req_i.data.amount;
          idx_d        = '0;
          cv_d         = 1'b0;
          have_best_d  = 1'b0;
          have_prev_d  = 1'b0;
          rank_d       = '0;
          res_key_d    = req_i.data.part_key;
          res_qty_d    = '0;
          res_last_d   = 1'b1;
          res_status_d = ST_OK;
          if (req_i.data.command == CMD_INSERT && count_q == FULL_COUNT) begin
            // full check comes before any duplicate check
            res_status_d = ST_FULL;
            state_d      = S_EMIT;
          end else if (req_i.data.command == CMD_LIST && count_q == '0) begin
            res_status_d = ST_EMPTY;
            res_key_d    = '0;
            state_d      = S_EMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue the next read while entries remain
        if (idx_q < count_q) begin
          cv_d   = 1'b1;
          cidx_d = idx_q[IDX_W-1:0];
          idx_d  = idx_q + CNT_W'(1);
        end else begin
          cv_d = 1'b0;
        end

        if (cv_q) begin
          if (cmd_q == CMD_LIST) begin
            // smallest key above the one emitted last
            if ((!have_prev_q || key_rd > prev_key_q) &&
                (!have_best_q || key_rd < best_key_q)) begin
              have_best_d = 1'b1;
              best_key_d  = key_rd;
              best_qty_d  = qty_rd;
            end
          end else if (key_rd == key_q) begin
            res_key_d  = key_q;
            res_last_d = 1'b1;
            state_d    = S_EMIT;
            case (cmd_q)
              CMD_INSERT: begin
                res_status_d = ST_DUP;
                res_qty_d    = qty_rd;
              end
              CMD_UPDATE: begin
                qty_we       = 1'b1;
                waddr        = cidx_q;
                qty_wdata    = sat_qty;
                res_status_d = ST_OK;
                res_qty_d    = sat_qty;
              end
              default: begin
                res_status_d = ST_OK;
                res_qty_d    = qty_rd;
              end
            endcase
          end
        end else if (idx_q >= count_q) begin
          // scan finished without a match
          res_key_d  = key_q;
          res_last_d = 1'b1;
          state_d    = S_EMIT;
          case (cmd_q)
            CMD_INSERT: begin
              key_we       = 1'b1;
              qty_we       = 1'b1;
              waddr        = count_q[IDX_W-1:0];
              qty_wdata    = amt_q;
              count_d      = count_q + CNT_W'(1);
              res_status_d = ST_OK;
              res_qty_d    = amt_q;
            end
            CMD_LIST: begin
              res_status_d = ST_OK;
              res_key_d    = best_key_q;
              res_qty_d    = best_qty_q;
              res_last_d   = ((rank_q + CNT_W'(1)) == count_q);
            end
            default: begin
              res_status_d = ST_MISSING;
              res_qty_d    = '0;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cmd_q == CMD_LIST && !res_last_q) begin
            // next listing pass
            rank_d      = rank_q + CNT_W'(1);
            have_prev_d = 1'b1;
            prev_key_d  = res_key_q;
            have_best_d = 1'b0;
            idx_d       = '0;
            cv_d        = 1'b0;
            state_d     = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cv_q        <= cv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    amt_q        <= amt_d;
    idx_q        <= idx_d;
    cidx_q       <= cidx_d;
    have_best_q  <= have_best_d;
    best_key_q   <= best_key_d;
    best_qty_q   <= best_qty_d;
    have_prev_q  <= have_prev_d;
    prev_key_q   <= prev_key_d;
    rank_q       <= rank_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_qty_q    <= res_qty_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_q.status       <= res_status_q;
      out_q.out_key      <= res_key_q;
      out_q.out_quantity <= res_qty_q;
      out_q.last         <= res_last_q;
    end
  end

`ifndef ASSERT_OFF
  // the record count never passes the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("record count above table size");

  // a new key is written only into a free slot, and the count follows
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> (count_q < FULL_COUNT))
    else $error("key written into a full table");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("record count did not advance on insert");

  // the compared entry always lies below the record count
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cv_q) |-> ({1'b0, cidx_q} < {1'b0, count_q}))
    else $error("scan compared an unused entry");
`endif

endmodule
